@@ sv/simple_risc_execute_unit_core_assert.svh @@
// Assertion macros for the execute unit checker.
// Expects aclk and aresetn in the scope of each use.
`ifndef SIMPLE_RISC_EXECUTE_UNIT_CORE_ASSERT_SVH
`define SIMPLE_RISC_EXECUTE_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define SREU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SREU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sreu_pkg.sv @@
// Shared constants for the simple RISC execute unit: sizes, opcodes, fault codes
// and the word layouts of both stream channels. No dependencies.
`timescale 1ns / 1ps

package sreu_pkg;

    localparam int REG_COUNT = 8;
    localparam int MEM_WORDS = 65536;

    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int IDX_W     = 4;
    localparam int IDX_CMP_W = IDX_W + 1;
    localparam int DATA_W    = 32;
    localparam int PC_W      = 16;
    localparam int IMM_W     = 16;
    localparam int CMD_W     = 5;
    localparam int OUT_IDX_W = 3;
    localparam int FAULT_W   = 2;

    localparam logic [IDX_W-1:0] IMM_REG  = 4'd1;
    localparam logic [IDX_W-1:0] LINK_REG = 4'd7;

    localparam logic [CMD_W-1:0] OP_ADD = 5'd0;
    localparam logic [CMD_W-1:0] OP_SUB = 5'd1;
    localparam logic [CMD_W-1:0] OP_LSF = 5'd2;
    localparam logic [CMD_W-1:0] OP_RSF = 5'd3;
    localparam logic [CMD_W-1:0] OP_AND = 5'd4;
    localparam logic [CMD_W-1:0] OP_OR  = 5'd5;
    localparam logic [CMD_W-1:0] OP_XOR = 5'd6;
    localparam logic [CMD_W-1:0] OP_LHI = 5'd7;
    localparam logic [CMD_W-1:0] OP_LD  = 5'd8;
    localparam logic [CMD_W-1:0] OP_ST  = 5'd9;
    localparam logic [CMD_W-1:0] OP_JLT = 5'd16;
    localparam logic [CMD_W-1:0] OP_JLE = 5'd17;
    localparam logic [CMD_W-1:0] OP_JEQ = 5'd18;
    localparam logic [CMD_W-1:0] OP_JNE = 5'd19;
    localparam logic [CMD_W-1:0] OP_JIN = 5'd20;
    localparam logic [CMD_W-1:0] OP_HLT = 5'd24;

    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_REG  = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_MEM  = 2'd2;
    localparam logic [FAULT_W-1:0] FAULT_OP   = 2'd3;

    // input word
    localparam int S_CMD_LO  = 0;
    localparam int S_DST_LO  = S_CMD_LO + CMD_W;
    localparam int S_SRCA_LO = S_DST_LO + IDX_W;
    localparam int S_SRCB_LO = S_SRCA_LO + IDX_W;
    localparam int S_IMM_LO  = S_SRCB_LO + IDX_W;
    localparam int S_USED_W  = S_IMM_LO + IMM_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // result word
    localparam int M_EPC_LO   = 0;
    localparam int M_NPC_LO   = M_EPC_LO + PC_W;
    localparam int M_WR_LO    = M_NPC_LO + PC_W;
    localparam int M_IDX_LO   = M_WR_LO + 1;
    localparam int M_VAL_LO   = M_IDX_LO + OUT_IDX_W;
    localparam int M_TAKEN_LO = M_VAL_LO + DATA_W;
    localparam int M_HALT_LO  = M_TAKEN_LO + 1;
    localparam int M_FAULT_LO = M_HALT_LO + 1;
    localparam int M_USED_W   = M_FAULT_LO + FAULT_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

endpackage

@@ sv/simple_risc_execute_unit_core.sv @@
// Simple RISC execute unit: register file, word memory, ALU, jumps and halt.
// Depends on sreu_pkg.
//
//   channel  | dir | handshake          | word
//   s_       | in  | s_tvalid/s_tready  | cmd, dest_reg, src_a_reg, src_b_reg, imm
//   m_       | out | m_tvalid/m_tready  | exec_pc, next_pc, write report, status
//
// One instruction per cycle while m_tready keeps up; a load that executes waits on the registered
// read port of the data memory. Register file read at accept, result registered.
// After reset a clearing pass over all MEM_WORDS words (65536) zeroes the data memory and
// register file; s_tready stays low meanwhile.
// m_tready low holds the result register and then the execute register, and s_tready
// falls. A halt or fault stops the unit; later words only report the held PC.
`timescale 1ns / 1ps

module simple_risc_execute_unit_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd, dest_reg, src_a_reg, src_b_reg, imm, zero fill
    input  logic [sreu_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // exec_pc, next_pc, wrote_reg, wrote_reg_index, wrote_reg_value,
    // branch_taken, halted, fault_code
    output logic [sreu_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int REG_AW = sreu_pkg::REG_AW;
    localparam int MEM_AW = sreu_pkg::MEM_AW;
    localparam int DW     = sreu_pkg::DATA_W;
    localparam int PW     = sreu_pkg::PC_W;
    localparam int IW     = sreu_pkg::IDX_W;

    logic [DW-1:0] rf_a_mem [sreu_pkg::REG_COUNT];
    logic [DW-1:0] rf_d_mem [sreu_pkg::REG_COUNT];
    logic [DW-1:0] dmem     [sreu_pkg::MEM_WORDS];

    logic [MEM_AW-1:0] clr_cnt_reg;
    logic              clr_done_reg;

    logic                      ex_valid_reg, ld_phase_reg;
    logic [sreu_pkg::CMD_W-1:0] ex_cmd_reg;
    logic [IW-1:0]             ex_d_reg, ex_a_reg, ex_b_reg;
    logic [sreu_pkg::IMM_W-1:0] ex_imm_reg;
    logic [DW-1:0]             rfa_q_reg, rfb_q_reg, rfd_q_reg, byp_val_reg, mem_q_reg;
    logic                      byp_a_reg, byp_b_reg, byp_d_reg;

    logic [PW-1:0] pc_reg;
    logic          stopped_reg;

    logic                          out_valid_reg;
    logic [PW-1:0]                 out_epc_reg, out_npc_reg;
    logic                          out_wr_reg, out_taken_reg, out_halt_reg;
    logic [sreu_pkg::OUT_IDX_W-1:0] out_idx_reg;
    logic [DW-1:0]                 out_val_reg;
    logic [sreu_pkg::FAULT_W-1:0]  out_fault_reg;

    logic [sreu_pkg::CMD_W-1:0] in_cmd;
    logic [IW-1:0]             in_d, in_a, in_b;
    logic [sreu_pkg::IMM_W-1:0] in_imm;
    logic                      accept, ex_adv, ex_done;

    logic [DW-1:0] imm32, va, vb, vd, alu_val;
    logic          regbad, vb_oob, dest_ok;
    logic          res_wr, res_taken, res_halt, load_go, load_issue, mem_we;
    logic [DW-1:0] res_val;
    logic [PW-1:0] res_npc;
    logic [sreu_pkg::FAULT_W-1:0] res_fault;
    logic          rf_we;
    logic [REG_AW-1:0] rf_widx;
    logic [DW-1:0] rf_wdata;
    logic [PW-1:0] pc_inc;

    assign in_cmd = s_tdata[sreu_pkg::S_CMD_LO +: sreu_pkg::CMD_W];
    assign in_d   = s_tdata[sreu_pkg::S_DST_LO +: IW];
    assign in_a   = s_tdata[sreu_pkg::S_SRCA_LO +: IW];
    assign in_b   = s_tdata[sreu_pkg::S_SRCB_LO +: IW];
    assign in_imm = s_tdata[sreu_pkg::S_IMM_LO +: sreu_pkg::IMM_W];

    assign ex_done  = !(load_go && !ld_phase_reg);
    assign ex_adv   = ex_valid_reg && ex_done && (!out_valid_reg || m_tready);
    assign s_tready = clr_done_reg && (!ex_valid_reg || ex_adv);
    assign accept   = s_tvalid && s_tready;

    assign imm32  = {{(DW - sreu_pkg::IMM_W){1'b0}}, ex_imm_reg};
    assign pc_inc = pc_reg + {{(PW-1){1'b0}}, 1'b1};

    assign va = (ex_a_reg == sreu_pkg::IMM_REG) ? imm32 : byp_a_reg ? byp_val_reg : rfa_q_reg;
    assign vb = (ex_b_reg == sreu_pkg::IMM_REG) ? imm32 : byp_b_reg ? byp_val_reg : rfb_q_reg;
    assign vd = (ex_d_reg == sreu_pkg::IMM_REG) ? imm32 : byp_d_reg ? byp_val_reg : rfd_q_reg;

    assign regbad = (sreu_pkg::IDX_CMP_W'(ex_d_reg) >=
                     sreu_pkg::IDX_CMP_W'(sreu_pkg::REG_COUNT)) ||
                    (sreu_pkg::IDX_CMP_W'(ex_a_reg) >=
                     sreu_pkg::IDX_CMP_W'(sreu_pkg::REG_COUNT)) ||
                    (sreu_pkg::IDX_CMP_W'(ex_b_reg) >=
                     sreu_pkg::IDX_CMP_W'(sreu_pkg::REG_COUNT));
    assign vb_oob  = {1'b0, vb} >= (DW+1)'(sreu_pkg::MEM_WORDS);
    assign dest_ok = ex_d_reg > sreu_pkg::IMM_REG;

    always_comb begin
        case (ex_cmd_reg)
            sreu_pkg::OP_ADD: alu_val = va + vb;
            sreu_pkg::OP_SUB: alu_val = va - vb;
            sreu_pkg::OP_LSF: alu_val = (vb[DW-1:5] != '0) ? '0 : (va << vb[4:0]);
            sreu_pkg::OP_RSF: alu_val = (vb[DW-1:5] != '0) ? '0 : (va >> vb[4:0]);
            sreu_pkg::OP_AND: alu_val = va & vb;
            sreu_pkg::OP_OR:  alu_val = va | vb;
            sreu_pkg::OP_XOR: alu_val = va ^ vb;
            sreu_pkg::OP_LHI: alu_val = {ex_imm_reg, vd[15:0]};
            default:          alu_val = mem_q_reg;
        endcase
    end

    always_comb begin
        res_wr    = 1'b0;
        res_val   = '0;
        res_taken = 1'b0;
        res_halt  = 1'b0;
        res_fault = sreu_pkg::FAULT_NONE;
        res_npc   = pc_inc;
        load_go   = 1'b0;
        mem_we    = 1'b0;
        if (stopped_reg) begin
            res_npc  = pc_reg;
            res_halt = 1'b1;
        end else begin
            case (ex_cmd_reg)
                sreu_pkg::OP_ADD, sreu_pkg::OP_SUB, sreu_pkg::OP_LSF, sreu_pkg::OP_RSF,
                sreu_pkg::OP_AND, sreu_pkg::OP_OR, sreu_pkg::OP_XOR, sreu_pkg::OP_LHI,
                sreu_pkg::OP_LD: begin
                    if (dest_ok) begin
                        if (regbad) begin
                            res_fault = sreu_pkg::FAULT_REG;
                        end else if (ex_cmd_reg == sreu_pkg::OP_LD && vb_oob) begin
                            res_fault = sreu_pkg::FAULT_MEM;
                        end else begin
                            load_go = (ex_cmd_reg == sreu_pkg::OP_LD);
                            res_wr  = 1'b1;
                            res_val = alu_val;
                        end
                    end
                end
                sreu_pkg::OP_ST: begin
                    if (regbad) begin
                        res_fault = sreu_pkg::FAULT_REG;
                    end else if (vb_oob) begin
                        res_fault = sreu_pkg::FAULT_MEM;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
                sreu_pkg::OP_JLT, sreu_pkg::OP_JLE, sreu_pkg::OP_JEQ, sreu_pkg::OP_JNE,
                sreu_pkg::OP_JIN: begin
                    if (regbad) begin
                        res_fault = sreu_pkg::FAULT_REG;
                    end else begin
                        case (ex_cmd_reg)
                            sreu_pkg::OP_JLT: res_taken = va < vb;
                            sreu_pkg::OP_JLE: res_taken = va <= vb;
                            sreu_pkg::OP_JEQ: res_taken = va == vb;
                            sreu_pkg::OP_JNE: res_taken = va != vb;
                            default:          res_taken = 1'b1;
                        endcase
                        if (res_taken) begin
                            res_npc = (ex_cmd_reg == sreu_pkg::OP_JIN) ? va[PW-1:0] : ex_imm_reg;
                        end
                    end
                end
                sreu_pkg::OP_HLT: res_halt = 1'b1;
                default:          res_fault = sreu_pkg::FAULT_OP;
            endcase
            if (res_fault != sreu_pkg::FAULT_NONE) begin
                res_halt = 1'b1;
            end
        end
    end

    assign load_issue = ex_valid_reg && load_go && !ld_phase_reg;
    assign rf_we      = ex_adv && !stopped_reg && (res_wr || res_taken);
    assign rf_widx    = res_taken ? sreu_pkg::LINK_REG[REG_AW-1:0] : ex_d_reg[REG_AW-1:0];
    assign rf_wdata   = res_taken ? {{(DW-PW){1'b0}}, pc_reg} : res_val;

    // register file copies: one read at src_a and src_b, one at dest
    always_ff @(posedge aclk) begin
        if (!clr_done_reg) begin
            rf_a_mem[clr_cnt_reg[REG_AW-1:0]] <= '0;
            rf_d_mem[clr_cnt_reg[REG_AW-1:0]] <= '0;
        end else if (rf_we) begin
            rf_a_mem[rf_widx] <= rf_wdata;
            rf_d_mem[rf_widx] <= rf_wdata;
        end
        if (accept) begin
            rfa_q_reg <= rf_a_mem[in_a[REG_AW-1:0]];
            rfb_q_reg <= rf_a_mem[in_b[REG_AW-1:0]];
            rfd_q_reg <= rf_d_mem[in_d[REG_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!clr_done_reg) begin
            dmem[clr_cnt_reg] <= '0;
        end else if (ex_adv && mem_we) begin
            dmem[vb[MEM_AW-1:0]] <= va;
        end
        if (load_issue) begin
            mem_q_reg <= dmem[vb[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_cmd_reg  <= in_cmd;
            ex_d_reg    <= in_d;
            ex_a_reg    <= in_a;
            ex_b_reg    <= in_b;
            ex_imm_reg  <= in_imm;
            byp_a_reg   <= rf_we && (rf_widx == in_a[REG_AW-1:0]);
            byp_b_reg   <= rf_we && (rf_widx == in_b[REG_AW-1:0]);
            byp_d_reg   <= rf_we && (rf_widx == in_d[REG_AW-1:0]);
            byp_val_reg <= rf_wdata;
        end
        if (ex_adv) begin
            out_epc_reg   <= pc_reg;
            out_npc_reg   <= res_npc;
            out_wr_reg    <= res_wr;
            out_idx_reg   <= res_wr ? ex_d_reg[sreu_pkg::OUT_IDX_W-1:0] : '0;
            out_val_reg   <= res_val;
            out_taken_reg <= res_taken;
            out_halt_reg  <= res_halt;
            out_fault_reg <= res_fault;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            clr_done_reg  <= 1'b0;
            ex_valid_reg  <= 1'b0;
            ld_phase_reg  <= 1'b0;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (!clr_done_reg) begin
                clr_cnt_reg <= clr_cnt_reg + {{(MEM_AW-1){1'b0}}, 1'b1};
                if (clr_cnt_reg == MEM_AW'(sreu_pkg::MEM_WORDS - 1)) begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (accept) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_adv) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_adv) begin
                ld_phase_reg <= 1'b0;
            end else if (load_issue) begin
                ld_phase_reg <= 1'b1;
            end
            if (ex_adv) begin
                pc_reg      <= res_npc;
                stopped_reg <= res_halt;
            end
            if (ex_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    always_comb begin
        m_tdata = '0;
        m_tdata[sreu_pkg::M_EPC_LO +: PW]                      = out_epc_reg;
        m_tdata[sreu_pkg::M_NPC_LO +: PW]                      = out_npc_reg;
        m_tdata[sreu_pkg::M_WR_LO]                             = out_wr_reg;
        m_tdata[sreu_pkg::M_IDX_LO +: sreu_pkg::OUT_IDX_W]     = out_idx_reg;
        m_tdata[sreu_pkg::M_VAL_LO +: DW]                      = out_val_reg;
        m_tdata[sreu_pkg::M_TAKEN_LO]                          = out_taken_reg;
        m_tdata[sreu_pkg::M_HALT_LO]                           = out_halt_reg;
        m_tdata[sreu_pkg::M_FAULT_LO +: sreu_pkg::FAULT_W]     = out_fault_reg;
    end

endmodule

@@ sv/sreu_checker.sv @@
// Port-level checker for the execute unit, bound to the top level.
// Depends on sreu_pkg and simple_risc_execute_unit_core_assert.svh.
`timescale 1ns / 1ps
`include "simple_risc_execute_unit_core_assert.svh"

module sreu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    // cmd, dest_reg, src_a_reg, src_b_reg, imm, zero fill
    input logic [sreu_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    // exec_pc, next_pc, wrote_reg, wrote_reg_index, wrote_reg_value,
    // branch_taken, halted, fault_code
    input logic [sreu_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                         s_acc, m_wr, m_taken, m_halt, s_any;
    logic [sreu_pkg::FAULT_W-1:0] m_fault;

    assign s_acc   = s_tvalid && s_tready;
    assign s_any   = ^s_tdata || !(^s_tdata);
    assign m_wr    = m_tdata[sreu_pkg::M_WR_LO];
    assign m_taken = m_tdata[sreu_pkg::M_TAKEN_LO];
    assign m_halt  = m_tdata[sreu_pkg::M_HALT_LO];
    assign m_fault = m_tdata[sreu_pkg::M_FAULT_LO +: sreu_pkg::FAULT_W];

    // hold a stalled result word
    `SREU_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
    // a new result follows an accepted word through the execute and result registers, after a read phase for a load
    `SREU_ASSERT_NOW(a_m_origin, $rose(m_tvalid), s_any && ($past(s_acc, 2) || $past(s_acc, 3)), "result without a matching input word")
    // a faulting word stops the unit and writes nothing
    `SREU_ASSERT_NOW(a_fault_stop, m_tvalid && (m_fault != sreu_pkg::FAULT_NONE), m_halt && !m_wr && !m_taken, "fault without stop")
    // clearing pass blocks input right after reset
    `SREU_ASSERT_NOW(a_clear_block, $rose(aresetn), !s_tready, "input taken during clearing pass")

endmodule

bind simple_risc_execute_unit_core sreu_checker u_sreu_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking bench for simple_risc_execute_unit_core: a queue-fed stream driver, a monitor
// and an in-bench instruction predictor compare every result word field by field.
// Depends on sreu_pkg and simple_risc_execute_unit_core.
`timescale 1ns / 1ps

module tb_top;
    import sreu_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RUN_ITEMS   = 1600;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] dst;
        logic [IDX_W-1:0] srca;
        logic [IDX_W-1:0] srcb;
        logic [IMM_W-1:0] imm;
        logic             drain;
    } instr_t;

    typedef struct packed {
        logic [PC_W-1:0]      exec_pc;
        logic [PC_W-1:0]      next_pc;
        logic                 wrote_reg;
        logic [OUT_IDX_W-1:0] wrote_idx;
        logic [DATA_W-1:0]    wrote_val;
        logic                 branch_taken;
        logic                 halted;
        logic [FAULT_W-1:0]   fault_code;
    } result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    instr_t  pending [$];
    result_t result_q [$];
    instr_t  cur_ins;
    logic    word_taken = 1'b0;

    // predicted machine state
    logic [DATA_W-1:0] regs_m [REG_COUNT];
    logic [DATA_W-1:0] mem_m [logic [MEM_AW-1:0]];
    logic [PC_W-1:0]   pc_m = '0;
    logic              cpu_stopped = 1'b0;

    int    err_cnt = 0;
    int    sent_cnt = 0;
    int    n_total = 1;
    int    n_checked = 0;
    int    n_taken = 0;
    int    n_mem = 0;
    int    cycle_cnt = 0;
    string stop_kind = "none";

    int send_idle [4] = '{0, 53, 0, 31};
    int recv_idle [4] = '{0, 0, 53, 31};

    logic [CMD_W-1:0] run_ops [15] = '{OP_ADD, OP_SUB, OP_LSF, OP_RSF, OP_AND, OP_OR, OP_XOR,
                                       OP_LHI, OP_LD, OP_ST, OP_JLT, OP_JLE, OP_JEQ, OP_JNE,
                                       OP_JIN};

    simple_risc_execute_unit_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic instr_t mk(logic [CMD_W-1:0] c, logic [IDX_W-1:0] d, a, b,
                                  logic [IMM_W-1:0] im);
        instr_t ins;
        ins.cmd   = c;
        ins.dst   = d;
        ins.srca  = a;
        ins.srcb  = b;
        ins.imm   = im;
        ins.drain = 1'b0;
        return ins;
    endfunction

    function automatic result_t execute_instr(instr_t ins);
        result_t           r;
        logic [PC_W-1:0]   npc;
        logic [DATA_W-1:0] va, vb, wval;
        logic [FAULT_W-1:0] flt;
        logic              regbad, halt_now, taken;
        r = '0;
        r.exec_pc = pc_m;
        if (cpu_stopped) begin
            r.next_pc = pc_m;
            r.halted  = 1'b1;
            return r;
        end
        npc      = pc_m + 16'd1;
        va       = '0;
        vb       = '0;
        wval     = '0;
        flt      = FAULT_NONE;
        halt_now = 1'b0;
        taken    = 1'b0;
        regs_m[IMM_REG] = {16'h0000, ins.imm};
        regbad = (ins.dst >= REG_COUNT) || (ins.srca >= REG_COUNT) || (ins.srcb >= REG_COUNT);
        if (!regbad) begin
            va = regs_m[ins.srca];
            vb = regs_m[ins.srcb];
        end
        if (ins.cmd <= OP_LD) begin
            if (ins.dst > IMM_REG) begin
                if (regbad) begin
                    flt = FAULT_REG;
                end else begin
                    case (ins.cmd)
                        OP_ADD: wval = va + vb;
                        OP_SUB: wval = va - vb;
                        OP_LSF: wval = (vb >= 32) ? '0 : va << vb[4:0];
                        OP_RSF: wval = (vb >= 32) ? '0 : va >> vb[4:0];
                        OP_AND: wval = va & vb;
                        OP_OR:  wval = va | vb;
                        OP_XOR: wval = va ^ vb;
                        OP_LHI: wval = {ins.imm, regs_m[ins.dst][15:0]};
                        default: begin
                            if (vb >= MEM_WORDS) begin
                                flt = FAULT_MEM;
                            end else begin
                                wval = mem_m.exists(vb[MEM_AW-1:0]) ? mem_m[vb[MEM_AW-1:0]] : '0;
                                n_mem++;
                            end
                        end
                    endcase
                    if (flt == FAULT_NONE) begin
                        regs_m[ins.dst] = wval;
                        r.wrote_reg = 1'b1;
                        r.wrote_idx = ins.dst[OUT_IDX_W-1:0];
                        r.wrote_val = wval;
                    end
                end
            end
        end else if (ins.cmd == OP_ST) begin
            if (regbad) begin
                flt = FAULT_REG;
            end else if (vb >= MEM_WORDS) begin
                flt = FAULT_MEM;
            end else begin
                mem_m[vb[MEM_AW-1:0]] = va;
                n_mem++;
            end
        end else if (ins.cmd >= OP_JLT && ins.cmd <= OP_JIN) begin
            if (regbad) begin
                flt = FAULT_REG;
            end else begin
                case (ins.cmd)
                    OP_JLT:  taken = va < vb;
                    OP_JLE:  taken = va <= vb;
                    OP_JEQ:  taken = va == vb;
                    OP_JNE:  taken = va != vb;
                    default: taken = 1'b1;
                endcase
                if (taken) begin
                    regs_m[LINK_REG] = {16'h0000, pc_m};
                    npc = (ins.cmd == OP_JIN) ? va[PC_W-1:0] : ins.imm;
                    n_taken++;
                end
            end
        end else if (ins.cmd == OP_HLT) begin
            halt_now = 1'b1;
        end else begin
            flt = FAULT_OP;
        end
        if (flt != FAULT_NONE)
            halt_now = 1'b1;
        if (halt_now)
            cpu_stopped = 1'b1;
        pc_m = npc;
        r.next_pc      = npc;
        r.branch_taken = taken;
        r.halted       = cpu_stopped;
        r.fault_code   = flt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // driver: hold the word until taken, then advance or idle
    always @(negedge aclk) begin : drv
        int ph;
        ph = (sent_cnt * 4) / n_total;
        if (ph > 3)
            ph = 3;
        if (aresetn && !(s_tvalid && !word_taken)) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_idle[ph] &&
                !(pending[0].drain && result_q.size() != 0)) begin
                cur_ins = pending.pop_front();
                s_tdata <= S_TDATA_W'({cur_ins.imm, cur_ins.srcb, cur_ins.srca,
                                       cur_ins.dst, cur_ins.cmd});
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle[ph]);
    end

    always @(posedge aclk) begin : mon
        result_t want, got;
        word_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                word_taken = 1'b1;
                sent_cnt++;
                result_q.push_back(execute_instr(cur_ins));
            end
            if (m_tvalid && m_tready) begin
                got.exec_pc      = m_tdata[M_EPC_LO +: PC_W];
                got.next_pc      = m_tdata[M_NPC_LO +: PC_W];
                got.wrote_reg    = m_tdata[M_WR_LO];
                got.wrote_idx    = m_tdata[M_IDX_LO +: OUT_IDX_W];
                got.wrote_val    = m_tdata[M_VAL_LO +: DATA_W];
                got.branch_taken = m_tdata[M_TAKEN_LO];
                got.halted       = m_tdata[M_HALT_LO];
                got.fault_code   = m_tdata[M_FAULT_LO +: FAULT_W];
                if (result_q.size() == 0) begin
                    $error("result word with nothing expected: 0x%0h", m_tdata);
                    err_cnt++;
                end else begin
                    want = result_q.pop_front();
                    n_checked++;
                    check_field("exec_pc", 32'(want.exec_pc), 32'(got.exec_pc));
                    check_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
                    check_field("wrote_reg", 32'(want.wrote_reg), 32'(got.wrote_reg));
                    check_field("wrote_reg_index", 32'(want.wrote_idx), 32'(got.wrote_idx));
                    check_field("wrote_reg_value", want.wrote_val, got.wrote_val);
                    check_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
                    check_field("halted", 32'(want.halted), 32'(got.halted));
                    check_field("fault_code", 32'(want.fault_code), 32'(got.fault_code));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                   result_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stim
        instr_t           ins;
        logic [CMD_W-1:0] c;
        logic [IDX_W-1:0] d, a, b;
        logic [IMM_W-1:0] im;
        int               k;
        for (k = 0; k < REG_COUNT; k++)
            regs_m[k] = '0;

        pending.push_back(mk(OP_LHI, 4'd2, 4'd0, 4'd0, 16'hFFFF));
        pending.push_back(mk(OP_ADD, 4'd2, 4'd2, 4'd1, 16'hFFFF));
        pending.push_back(mk(OP_ADD, 4'd3, 4'd2, 4'd1, 16'h0001));
        pending.push_back(mk(OP_SUB, 4'd4, 4'd3, 4'd1, 16'h0001));
        pending.push_back(mk(OP_LSF, 4'd5, 4'd4, 4'd1, 16'd31));
        pending.push_back(mk(OP_LSF, 4'd6, 4'd4, 4'd1, 16'd32));
        pending.push_back(mk(OP_RSF, 4'd5, 4'd4, 4'd1, 16'd0));
        pending.push_back(mk(OP_RSF, 4'd6, 4'd4, 4'd2, 16'd0));
        pending.push_back(mk(OP_AND, 4'd6, 4'd4, 4'd1, 16'hA5A5));
        pending.push_back(mk(OP_OR,  4'd6, 4'd3, 4'd1, 16'h8001));
        pending.push_back(mk(OP_XOR, 4'd7, 4'd4, 4'd1, 16'h00FF));
        pending.push_back(mk(OP_ST,  4'd0, 4'd4, 4'd1, 16'hFFFF));
        pending.push_back(mk(OP_ST,  4'd0, 4'd3, 4'd1, 16'h0000));
        pending.push_back(mk(OP_LD,  4'd2, 4'd0, 4'd1, 16'hFFFF));
        pending.push_back(mk(OP_LD,  4'd3, 4'd0, 4'd1, 16'h0001));
        pending.push_back(mk(OP_JLT, 4'd0, 4'd3, 4'd4, 16'h1234));
        pending.push_back(mk(OP_JLE, 4'd0, 4'd4, 4'd4, 16'h0000));
        pending.push_back(mk(OP_JEQ, 4'd0, 4'd3, 4'd4, 16'h5555));
        pending.push_back(mk(OP_JNE, 4'd0, 4'd3, 4'd3, 16'h5555));
        pending.push_back(mk(OP_JIN, 4'd0, 4'd4, 4'd0, 16'h0000));
        // writes to registers 0 and 1 are dropped, bad source indices included
        pending.push_back(mk(OP_ADD, 4'd0, 4'd15, 4'd9, 16'h0000));
        pending.push_back(mk(OP_LHI, 4'd1, 4'd8, 4'd15, 16'hFFFF));
        pending.push_back(mk(OP_JEQ, 4'd7, 4'd7, 4'd7, 16'h0000));

        for (k = 0; k < RUN_ITEMS; k++) begin
            c  = run_ops[$urandom_range(14)];
            d  = 4'($urandom_range(2, 7));
            a  = 4'($urandom_range(7));
            b  = 4'($urandom_range(7));
            im = 16'($urandom);
            if (c <= OP_LD && $urandom_range(9) == 0) begin
                d = 4'($urandom_range(1));
                a = 4'($urandom_range(15));
                b = 4'($urandom_range(15));
            end else if (c == OP_LD || c == OP_ST) begin
                b  = IMM_REG;
                im = ($urandom_range(3) != 0) ? 16'($urandom_range(15)) : 16'($urandom);
                if (c == OP_ST)
                    d = 4'($urandom_range(7));
            end else if ((c == OP_LSF || c == OP_RSF) && $urandom_range(1) == 1) begin
                b  = IMM_REG;
                im = 16'($urandom_range(40));
            end else if (c > OP_LD) begin
                d = 4'($urandom_range(7));
                if ($urandom_range(3) == 0)
                    b = a;
            end
            ins = mk(c, d, a, b, im);
            ins.drain = (k == 500 || k == 1100);
            pending.push_back(ins);
        end

        // one stopping word per run, picked by the seed
        case ($urandom_range(3))
            0: begin
                stop_kind = "halt";
                pending.push_back(mk(OP_HLT, 4'($urandom), 4'($urandom), 4'($urandom),
                                     16'($urandom)));
            end
            1: begin
                stop_kind = "bad register index";
                pending.push_back(mk(run_ops[$urandom_range(14)], 4'($urandom_range(8, 15)),
                                     4'($urandom), 4'($urandom), 16'($urandom)));
            end
            2: begin
                stop_kind = "bad memory address";
                pending.push_back(mk(OP_LHI, 4'd3, 4'd0, 4'd0, 16'($urandom_range(1, 65535))));
                pending.push_back(mk($urandom_range(1) ? OP_LD : OP_ST, 4'($urandom_range(2, 7)),
                                     4'($urandom_range(7)), 4'd3, 16'($urandom)));
            end
            default: begin
                stop_kind = "unknown opcode";
                do
                    c = 5'($urandom);
                while (c <= OP_ST || (c >= OP_JLT && c <= OP_JIN) || c == OP_HLT);
                pending.push_back(mk(c, 4'($urandom), 4'($urandom), 4'($urandom),
                                     16'($urandom)));
            end
        endcase
        repeat (24)
            pending.push_back(mk(5'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                                 16'($urandom)));
        n_total = pending.size();

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid || result_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d words up to a stop by %s; %0d results checked, %0d taken jumps,",
                 sent_cnt, stop_kind, n_checked, n_taken);
        $display("%0d memory accesses, under four idle and stall mixes.", n_mem);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/sreu_pkg.sv
sv/simple_risc_execute_unit_core.sv
sv/sreu_checker.sv
tb/sv/tb_top.sv
